FILE: rtl/core/trace_reorder_buffer_assert.svh
// Assertion helpers for the trace reorder buffer.
// Both expect clk and rst in the scope of the use.
`ifndef TRACE_REORDER_BUFFER_ASSERT_SVH
`define TRACE_REORDER_BUFFER_ASSERT_SVH

// Same-cycle implication.
`define TRB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TRB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/trb_pkg.sv
`default_nettype none

package trb_pkg;

  localparam int OPCODE_W = 2;
  localparam int WORD_W   = 64;
  localparam int INSTR_W  = 32;
  localparam int TAG_W    = 8;
  localparam int PRIV_W   = 3;

  localparam int QUEUE_DEPTH_DEF   = 32;
  localparam int PENDING_DEPTH_DEF = 16;
  localparam int DATA_WIDTH_DEF    = 64;

  localparam logic [OPCODE_W-1:0] OP_PUSH_TRACE = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_PUSH_WB    = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_POP        = 2'd2;

  typedef struct packed {
    logic              interrupt;
    logic              exception;
    logic [PRIV_W-1:0] privilege;
    logic [TAG_W-1:0]  tag;
    logic              waiting;
  } trb_flags_t;

  // Fixed part of one queue entry; writeback data is appended beside it.
  typedef struct packed {
    logic [WORD_W-1:0]  address;
    logic [INSTR_W-1:0] instr;
    logic [WORD_W-1:0]  cause;
    logic [WORD_W-1:0]  trap_value;
    trb_flags_t         flags;
  } trb_rec_t;

  localparam int REC_W = $bits(trb_rec_t);

endpackage

`default_nettype wire

FILE: rtl/core/trb_if.sv
`default_nettype none

interface trb_req_if;
  import trb_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic                should_write_back;
  logic                has_write_back;
  logic [TAG_W-1:0]    tag;
  logic [WORD_W-1:0]   instr_address;
  logic [INSTR_W-1:0]  instr_word;
  logic [PRIV_W-1:0]   privilege;
  logic                is_exception;
  logic                is_interrupt;
  logic [WORD_W-1:0]   trap_cause;
  logic [WORD_W-1:0]   trap_value;
  logic [WORD_W-1:0]   data_word;

  modport source (
    output valid, opcode, should_write_back, has_write_back, tag, instr_address,
           instr_word, privilege, is_exception, is_interrupt, trap_cause,
           trap_value, data_word,
    input  ready
  );

  modport sink (
    input  valid, opcode, should_write_back, has_write_back, tag, instr_address,
           instr_word, privilege, is_exception, is_interrupt, trap_cause,
           trap_value, data_word,
    output ready
  );
endinterface

interface trb_rsp_if;
  import trb_pkg::*;

  logic               valid;
  logic               ready;
  logic               record_valid;
  logic               dropped;
  logic [WORD_W-1:0]  out_address;
  logic [INSTR_W-1:0] out_instr;
  logic [PRIV_W-1:0]  out_privilege;
  logic               out_exception;
  logic               out_interrupt;
  logic [WORD_W-1:0]  out_cause;
  logic [WORD_W-1:0]  out_trap_value;
  logic [WORD_W-1:0]  out_data;

  modport source (
    output valid, record_valid, dropped, out_address, out_instr, out_privilege,
           out_exception, out_interrupt, out_cause, out_trap_value, out_data,
    input  ready
  );

  modport sink (
    input  valid, record_valid, dropped, out_address, out_instr, out_privilege,
           out_exception, out_interrupt, out_cause, out_trap_value, out_data,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/trb_ram.sv
`default_nettype none

module trb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/trace_reorder_buffer.sv
`default_nettype none

// Trace reorder buffer: holds retired-instruction trace records in order and
// joins late writeback data to them by tag. A trace push (opcode 0) appends a
// record; it is marked waiting when it should carry writeback data but did not
// bring it. A writeback push (opcode 1) appends a tag/data pair to the pending
// list, oldest first. A pop (opcode 2) gives the head record if it is
// complete; a waiting head first takes the data of the oldest pending entry
// with its tag, which leaves the list. Otherwise the pop returns record_valid
// low with zero fields. A push into a full store is refused with dropped set.
// Every request yields exactly one response. Records live in one RAM of
// QUEUE_DEPTH entries and the pending list in one RAM of PENDING_DEPTH
// entries, both with a registered read; no clearing pass runs after reset. A
// push, an unknown opcode or a pop of an empty queue is answered straight
// from idle. A pop reads the head record and answers from it when the head
// is complete or nothing is pending; for a waiting head the pending RAM is
// scanned one entry a cycle from the oldest, and after a match the younger
// entries move down one a cycle through the same RAM before the next request
// is taken. The pending RAM has a single read port. The response sits in an
// output register, so the next request is taken while a response is being
// handed over.
module trace_reorder_buffer #(
  parameter int QUEUE_DEPTH   = trb_pkg::QUEUE_DEPTH_DEF,
  parameter int PENDING_DEPTH = trb_pkg::PENDING_DEPTH_DEF,
  parameter int DATA_WIDTH    = trb_pkg::DATA_WIDTH_DEF
) (
  input wire logic clk,
  input wire logic rst,
  trb_req_if.sink  req,
  trb_rsp_if.source rsp
);

  import trb_pkg::*;

  `include "trace_reorder_buffer_assert.svh"

  localparam int QA_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int PA_W  = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int PC_W  = $clog2(PENDING_DEPTH + 1);
  localparam int CMP_W = PC_W + 1;
  localparam int QE_W  = REC_W + DATA_WIDTH;
  localparam int PE_W  = TAG_W + DATA_WIDTH;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_QREAD  = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;
  localparam logic [1:0] S_SHIFT  = 2'd3;

  typedef struct packed {
    logic               record_valid;
    logic               dropped;
    logic [WORD_W-1:0]  address;
    logic [INSTR_W-1:0] instr;
    logic [PRIV_W-1:0]  privilege;
    logic               exception;
    logic               interrupt;
    logic [WORD_W-1:0]  cause;
    logic [WORD_W-1:0]  trap_value;
    logic [WORD_W-1:0]  data;
  } rsp_t;

  // Control state
  logic [1:0]      state, state_next;
  logic [QA_W-1:0] q_head, q_head_next;
  logic [QA_W-1:0] q_tail, q_tail_next;
  logic [QC_W-1:0] q_count, q_count_next;
  logic [PC_W-1:0] p_count, p_count_next;
  logic [PA_W-1:0] scan, scan_next;
  logic            rsp_valid, rsp_valid_next;

  // Response payload
  rsp_t rsp_q, rsp_next;
  logic rsp_load;

  // RAM ports
  logic            q_we, q_re;
  logic [QE_W-1:0] q_wdata, q_rdata;
  logic            p_we, p_re;
  logic [PA_W-1:0] p_waddr, p_raddr;
  logic [PE_W-1:0] p_wdata, p_rdata;

  logic                  req_fire;
  logic                  q_full, p_full;
  trb_rec_t              q_rec, push_rec;
  logic [DATA_WIDTH-1:0] q_data;
  logic [TAG_W-1:0]      p_tag;
  logic [DATA_WIDTH-1:0] p_data;
  logic [CMP_W-1:0]      scan_ext, p_count_ext, scan_plus1, scan_plus2;

  assign req_fire = req.valid && req.ready;
  // Take a request only between pops and when the response slot frees up.
  assign req.ready = (state == S_IDLE) && (!rsp_valid || rsp.ready);

  assign q_full = (q_count == QC_W'(QUEUE_DEPTH));
  assign p_full = (p_count == PC_W'(PENDING_DEPTH));

  assign {q_rec, q_data} = q_rdata;
  assign {p_tag, p_data} = p_rdata;

  assign scan_ext    = CMP_W'(scan);
  assign p_count_ext = CMP_W'(p_count);
  assign scan_plus1  = scan_ext + CMP_W'(1);
  assign scan_plus2  = scan_ext + CMP_W'(2);

  // Pack an incoming trace record.
  always_comb begin
    push_rec.address         = req.instr_address;
    push_rec.instr           = req.instr_word;
    push_rec.cause           = req.trap_cause;
    push_rec.trap_value      = req.trap_value;
    push_rec.flags.waiting   = req.should_write_back && !req.has_write_back;
    push_rec.flags.tag       = req.tag;
    push_rec.flags.privilege = req.privilege;
    push_rec.flags.exception = req.is_exception;
    push_rec.flags.interrupt = req.is_interrupt;
  end

  assign q_wdata = {push_rec, req.data_word[DATA_WIDTH-1:0]};

  trb_ram #(
    .WIDTH (QE_W),
    .DEPTH (QUEUE_DEPTH),
    .AW    (QA_W)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_tail),
    .wdata (q_wdata),
    .re    (q_re),
    .raddr (q_head),
    .rdata (q_rdata)
  );

  trb_ram #(
    .WIDTH (PE_W),
    .DEPTH (PENDING_DEPTH),
    .AW    (PA_W)
  ) u_pending_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .re    (p_re),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  always_comb begin
    state_next   = state;
    q_head_next  = q_head;
    q_tail_next  = q_tail;
    q_count_next = q_count;
    p_count_next = p_count;
    scan_next    = scan;
    rsp_load     = 1'b0;
    rsp_next     = '0;
    q_we         = 1'b0;
    q_re         = 1'b0;
    p_we         = 1'b0;
    p_re         = 1'b0;
    p_waddr      = p_count[PA_W-1:0];
    p_wdata      = {req.tag, req.data_word[DATA_WIDTH-1:0]};
    p_raddr      = scan;

    case (state)
      S_IDLE: begin
        if (req_fire) begin
          case (req.opcode)
            OP_PUSH_TRACE: begin
              rsp_load = 1'b1;
              if (q_full) begin
                rsp_next.dropped = 1'b1;
              end else begin
                q_we         = 1'b1;
                q_tail_next  = (q_tail == QA_W'(QUEUE_DEPTH - 1)) ? '0 : q_tail + QA_W'(1);
                q_count_next = q_count + QC_W'(1);
              end
            end
            OP_PUSH_WB: begin
              rsp_load = 1'b1;
              if (p_full) begin
                rsp_next.dropped = 1'b1;
              end else begin
                p_we         = 1'b1;
                p_count_next = p_count + PC_W'(1);
              end
            end
            OP_POP: begin
              if (q_count == '0) begin
                rsp_load = 1'b1;
              end else begin
                q_re       = 1'b1;
                state_next = S_QREAD;
              end
            end
            default: begin
              rsp_load = 1'b1;
            end
          endcase
        end
      end

      S_QREAD: begin
        if (!q_rec.flags.waiting || p_count == '0) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end else begin
          // Start the tag scan at the oldest pending entry.
          p_re       = 1'b1;
          p_raddr    = '0;
          scan_next  = '0;
          state_next = S_SEARCH;
        end
      end

      S_SEARCH: begin
        if (p_tag == q_rec.flags.tag) begin
          rsp_load     = 1'b1;
          p_count_next = p_count - PC_W'(1);
          if (scan_plus1 < p_count_ext) begin
            // Close the gap: fetch the next younger entry.
            p_re       = 1'b1;
            p_raddr    = scan_plus1[PA_W-1:0];
            state_next = S_SHIFT;
          end else begin
            state_next = S_IDLE;
          end
        end else if (scan_plus1 < p_count_ext) begin
          p_re      = 1'b1;
          p_raddr   = scan_plus1[PA_W-1:0];
          scan_next = scan_plus1[PA_W-1:0];
        end else begin
          // No match: head stays waiting.
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_SHIFT: begin
        // Entry scan+1 is on the read port; move it down to scan.
        p_we    = 1'b1;
        p_waddr = scan;
        p_wdata = p_rdata;
        if (scan_plus2 <= p_count_ext) begin
          p_re      = 1'b1;
          p_raddr   = scan_plus2[PA_W-1:0];
          scan_next = scan_plus1[PA_W-1:0];
        end else begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Emit the head record and advance the queue.
    if (rsp_load && (state == S_QREAD || state == S_SEARCH) &&
        (!q_rec.flags.waiting || (state == S_SEARCH && p_tag == q_rec.flags.tag))) begin
      rsp_next.record_valid = 1'b1;
      rsp_next.address      = q_rec.address;
      rsp_next.instr        = q_rec.instr;
      rsp_next.privilege    = q_rec.flags.privilege;
      rsp_next.exception    = q_rec.flags.exception;
      rsp_next.interrupt    = q_rec.flags.interrupt;
      rsp_next.cause        = q_rec.cause;
      rsp_next.trap_value   = q_rec.trap_value;
      rsp_next.data         = q_rec.flags.waiting ? WORD_W'(p_data) : WORD_W'(q_data);
      q_head_next  = (q_head == QA_W'(QUEUE_DEPTH - 1)) ? '0 : q_head + QA_W'(1);
      q_count_next = q_count - QC_W'(1);
    end

    // Hold the response until taken.
    if (rsp_load) begin
      rsp_valid_next = 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      q_head    <= '0;
      q_tail    <= '0;
      q_count   <= '0;
      p_count   <= '0;
      scan      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      q_head    <= q_head_next;
      q_tail    <= q_tail_next;
      q_count   <= q_count_next;
      p_count   <= p_count_next;
      scan      <= scan_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_q <= rsp_next;
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.record_valid   = rsp_q.record_valid;
  assign rsp.dropped        = rsp_q.dropped;
  assign rsp.out_address    = rsp_q.address;
  assign rsp.out_instr      = rsp_q.instr;
  assign rsp.out_privilege  = rsp_q.privilege;
  assign rsp.out_exception  = rsp_q.exception;
  assign rsp.out_interrupt  = rsp_q.interrupt;
  assign rsp.out_cause      = rsp_q.cause;
  assign rsp.out_trap_value = rsp_q.trap_value;
  assign rsp.out_data       = rsp_q.data;

  `TRB_ASSERT_IMP(a_rsp_no_overwrite, rsp_load, (!rsp_valid || rsp.ready),
                  "response loaded over one not yet taken")
  `TRB_ASSERT_IMP(a_scan_in_range, (state == S_SEARCH), (scan_ext < p_count_ext),
                  "tag scan beyond pending entries")
  `TRB_ASSERT_NXT(a_pop_reads_head, (req_fire && req.opcode == OP_POP && q_count != '0),
                  (state == S_QREAD), "pop of nonempty queue did not read head")
  `TRB_ASSERT_IMP(a_queue_bound, 1'b1, (q_count <= QC_W'(QUEUE_DEPTH)),
                  "queue count above depth")

endmodule

`default_nettype wire

FILE: bench/trb_checker.sv
`default_nettype none

// Watches both channels of the trace reorder buffer, predicts the response of
// every accepted request and compares it with what the block hands over.
module trb_checker (
  input  wire logic clk,
  input  wire logic rst,
  trb_req_if        req,
  trb_rsp_if        rsp,
  output int        failures,
  output int        owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import trb_pkg::*;

  typedef struct packed {
    logic               record_valid;
    logic               dropped;
    logic [WORD_W-1:0]  address;
    logic [INSTR_W-1:0] instr;
    logic [PRIV_W-1:0]  privilege;
    logic               exception;
    logic               interrupt;
    logic [WORD_W-1:0]  cause;
    logic [WORD_W-1:0]  trap_value;
    logic [WORD_W-1:0]  data;
  } outcome_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [WORD_W-1:0] data;
  } late_wb_t;

  trb_rec_t          slot_rec  [QUEUE_DEPTH_DEF];
  logic [WORD_W-1:0] slot_data [QUEUE_DEPTH_DEF];
  int                head_idx;
  int                held;
  late_wb_t          late_wbs [$];
  outcome_t          awaited  [$];
  int                errors;

  // Apply the request now on the channel to the shadow store and return the
  // response it must produce.
  function automatic outcome_t next_outcome();
    outcome_t o;
    trb_rec_t r;
    late_wb_t w;
    int       slot;
    int       hit;
    o = '0;
    case (req.opcode)
      OP_PUSH_TRACE: begin
        if (held == QUEUE_DEPTH_DEF) begin
          o.dropped = 1'b1;
        end else begin
          slot = (head_idx + held) % QUEUE_DEPTH_DEF;
          r.address         = req.instr_address;
          r.instr           = req.instr_word;
          r.cause           = req.trap_cause;
          r.trap_value      = req.trap_value;
          r.flags.waiting   = req.should_write_back & ~req.has_write_back;
          r.flags.tag       = req.tag;
          r.flags.privilege = req.privilege;
          r.flags.exception = req.is_exception;
          r.flags.interrupt = req.is_interrupt;
          slot_rec[slot]    = r;
          slot_data[slot]   = WORD_W'(req.data_word[DATA_WIDTH_DEF-1:0]);
          held++;
        end
      end
      OP_PUSH_WB: begin
        if (late_wbs.size() == PENDING_DEPTH_DEF) begin
          o.dropped = 1'b1;
        end else begin
          w.tag  = req.tag;
          w.data = WORD_W'(req.data_word[DATA_WIDTH_DEF-1:0]);
          late_wbs.insert(late_wbs.size(), w);
        end
      end
      OP_POP: begin
        if (held != 0) begin
          r = slot_rec[head_idx];
          if (r.flags.waiting) begin
            hit = -1;
            foreach (late_wbs[i]) begin
              if (hit < 0 && late_wbs[i].tag == r.flags.tag) hit = i;
            end
            if (hit >= 0) begin
              slot_data[head_idx] = late_wbs[hit].data;
              r.flags.waiting     = 1'b0;
              slot_rec[head_idx]  = r;
              late_wbs.delete(hit);
            end
          end
          if (!r.flags.waiting) begin
            o.record_valid = 1'b1;
            o.address      = r.address;
            o.instr        = r.instr;
            o.privilege    = r.flags.privilege;
            o.exception    = r.flags.exception;
            o.interrupt    = r.flags.interrupt;
            o.cause        = r.cause;
            o.trap_value   = r.trap_value;
            o.data         = slot_data[head_idx];
            head_idx = (head_idx + 1) % QUEUE_DEPTH_DEF;
            held--;
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic note_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= 10) $display("response mismatch on %s: expected %h, got %h", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      head_idx = 0;
      held     = 0;
      errors   = 0;
      late_wbs.delete();
      awaited.delete();
    end else begin
      if (req.valid && req.ready) awaited.insert(awaited.size(), next_outcome());
      if (rsp.valid && rsp.ready) begin
        if (awaited.size() == 0) begin
          errors++;
          if (errors <= 10) $display("response with no request awaiting it");
        end else begin
          want = awaited[0];
          awaited.delete(0);
          note_field("record_valid", WORD_W'(want.record_valid), WORD_W'(rsp.record_valid));
          note_field("dropped", WORD_W'(want.dropped), WORD_W'(rsp.dropped));
          note_field("out_address", want.address, rsp.out_address);
          note_field("out_instr", WORD_W'(want.instr), WORD_W'(rsp.out_instr));
          note_field("out_privilege", WORD_W'(want.privilege), WORD_W'(rsp.out_privilege));
          note_field("out_exception", WORD_W'(want.exception), WORD_W'(rsp.out_exception));
          note_field("out_interrupt", WORD_W'(want.interrupt), WORD_W'(rsp.out_interrupt));
          note_field("out_cause", want.cause, rsp.out_cause);
          note_field("out_trap_value", want.trap_value, rsp.out_trap_value);
          note_field("out_data", want.data, rsp.out_data);
        end
      end
    end
    failures <= errors;
    owed     <= awaited.size();
  end

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`default_nettype none

// Stimulus and verdict for the trace reorder buffer. The checker beside the
// block predicts and compares; this module only makes requests, throttles the
// response side and decides the outcome.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import trb_pkg::*;

  // Opcode the block must ignore; it still answers with an all-zero response.
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  localparam int ITEM_TARGET  = 1750;
  localparam int CALM_TAIL    = 250;     // last requests go without any idling
  localparam int HOLD_AT      = 300;     // request count that arms the long hold-off
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 64;      // longest scan plus shift-down, with margin
  localparam int CYCLE_LIMIT  = 600000;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic                needs_wb;
    logic                has_wb;
    logic [TAG_W-1:0]    tag;
    logic [WORD_W-1:0]   address;
    logic [INSTR_W-1:0]  instr;
    logic [PRIV_W-1:0]   privilege;
    logic                exception;
    logic                interrupt;
    logic [WORD_W-1:0]   cause;
    logic [WORD_W-1:0]   trap_value;
    logic [WORD_W-1:0]   data;
  } trace_req_t;

  logic clk;
  logic rst;
  int   failures;
  int   owed;
  int   sent;
  int   gap_pct;
  int   cycle_count;
  bit   calm;
  bit   hold_due;

  trb_req_if req ();
  trb_rsp_if rsp ();

  trace_reorder_buffer dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  trb_checker u_check (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .failures (failures),
    .owed     (owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run (every pop scanning and
  // shifting the full pending list, every gap and stall at its longest).
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Words lean on the extremes now and then so that all-zero and all-one
  // values keep showing up next to plain random ones.
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly a tiny pool, so duplicate tags are common; sometimes any tag.
  function automatic logic [TAG_W-1:0] pick_tag();
    if ($urandom_range(0, 3) == 0) return TAG_W'($urandom);
    return TAG_W'($urandom_range(0, 3));
  endfunction

  // Fill every field at random, including the ones the opcode ignores.
  function automatic trace_req_t random_req(logic [OPCODE_W-1:0] op);
    trace_req_t r;
    r.opcode     = op;
    r.needs_wb   = 1'($urandom);
    r.has_wb     = 1'($urandom);
    r.tag        = TAG_W'($urandom);
    r.address    = pick_word();
    r.instr      = INSTR_W'($urandom);
    r.privilege  = PRIV_W'($urandom);
    r.exception  = 1'($urandom);
    r.interrupt  = 1'($urandom);
    r.cause      = pick_word();
    r.trap_value = pick_word();
    r.data       = pick_word();
    return r;
  endfunction

  function automatic trace_req_t waiting_rec(logic [TAG_W-1:0] t);
    trace_req_t r;
    r          = random_req(OP_PUSH_TRACE);
    r.needs_wb = 1'b1;
    r.has_wb   = 1'b0;
    r.tag      = t;
    return r;
  endfunction

  function automatic trace_req_t wb_for(logic [TAG_W-1:0] t);
    trace_req_t w;
    w     = random_req(OP_PUSH_WB);
    w.tag = t;
    return w;
  endfunction

  // Offer one request and hold it until the block takes it. A random idle
  // burst may come first; valid gets one update per edge either way.
  task automatic send(input trace_req_t r);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    req.valid             <= 1'b1;
    req.opcode            <= r.opcode;
    req.should_write_back <= r.needs_wb;
    req.has_write_back    <= r.has_wb;
    req.tag               <= r.tag;
    req.instr_address     <= r.address;
    req.instr_word        <= r.instr;
    req.privilege         <= r.privilege;
    req.is_exception      <= r.exception;
    req.is_interrupt      <= r.interrupt;
    req.trap_cause        <= r.cause;
    req.trap_value        <= r.trap_value;
    req.data_word         <= r.data;
    do @(posedge clk); while (!req.ready);
    if (r.opcode != OP_UNUSED) sent++;
  endtask

  // Well-formed batch from an empty block: up to eight records, a writeback
  // for every waiting one in shuffled order, pops sprinkled in, then enough
  // pops to drain. Duplicate tags pair up oldest first, so nothing is left.
  task automatic run_batch();
    trace_req_t recs [$];
    trace_req_t wbs  [$];
    trace_req_t r;
    trace_req_t tmp;
    int         n;
    int         j;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      r = random_req(OP_PUSH_TRACE);
      case ($urandom_range(0, 5))
        0: r.needs_wb = 1'b0;
        1: begin
          r.needs_wb = 1'b1;
          r.has_wb   = 1'b1;
        end
        default: begin
          r = waiting_rec(pick_tag());
          wbs.insert(wbs.size(), wb_for(r.tag));
        end
      endcase
      recs.insert(recs.size(), r);
    end
    for (int i = wbs.size() - 1; i > 0; i--) begin
      j      = $urandom_range(0, i);
      tmp    = wbs[i];
      wbs[i] = wbs[j];
      wbs[j] = tmp;
    end
    while (recs.size() != 0 || wbs.size() != 0) begin
      if ($urandom_range(0, 99) < 15) begin
        send(random_req(OP_POP));
      end else if ($urandom_range(0, 99) < 4) begin
        send(random_req(OP_UNUSED));
      end else if (wbs.size() == 0 || (recs.size() != 0 && $urandom_range(0, 1) == 0)) begin
        r = recs[0];
        recs.delete(0);
        send(r);
      end else begin
        r = wbs[0];
        wbs.delete(0);
        send(r);
      end
    end
    repeat (n) send(random_req(OP_POP));
  endtask

  // Overfill the record queue with complete records, then drain it.
  task automatic run_queue_flood();
    trace_req_t r;
    int         n;
    n = QUEUE_DEPTH_DEF + $urandom_range(1, 3);
    repeat (n) begin
      r        = random_req(OP_PUSH_TRACE);
      r.has_wb = 1'b1;
      send(r);
    end
    repeat (n) send(random_req(OP_POP));
  endtask

  // Overfill the pending list, then push waiting records for the accepted
  // tags in shuffled order so matches land deep in the list, and drain.
  task automatic run_pending_flood();
    logic [TAG_W-1:0] tags [$];
    logic [TAG_W-1:0] t;
    int               m;
    int               j;
    m = PENDING_DEPTH_DEF + $urandom_range(1, 3);
    for (int i = 0; i < m; i++) begin
      t = pick_tag();
      if (i < PENDING_DEPTH_DEF) tags.insert(tags.size(), t);
      send(wb_for(t));
    end
    for (int i = tags.size() - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      t       = tags[i];
      tags[i] = tags[j];
      tags[j] = t;
    end
    foreach (tags[i]) send(waiting_rec(tags[i]));
    repeat (tags.size()) send(random_req(OP_POP));
  endtask

  // Broken order: a writeback with no record yet, a record whose data comes
  // late (pops in between find it waiting unless it takes the stray entry),
  // then a record that soaks up the entry left over so the block ends clean.
  task automatic run_stray();
    logic [TAG_W-1:0] t_stray;
    logic [TAG_W-1:0] t_late;
    t_stray = pick_tag();
    t_late  = pick_tag();
    send(wb_for(t_stray));
    send(random_req(OP_POP));
    send(waiting_rec(t_late));
    repeat ($urandom_range(1, 3)) send(random_req(OP_POP));
    send(wb_for(t_late));
    send(random_req(OP_POP));
    send(waiting_rec(t_stray));
    send(random_req(OP_POP));
  endtask

  // Response side: random stall bursts in stretches of varying density, one
  // long hold-off so the output register backs up and the input stalls, and
  // no stalls at all once the tail of the run begins.
  initial begin
    int  stall_pct;
    int  stretch;
    bit  hold_taken;
    rsp.ready <= 1'b0;
    stall_pct  = 0;
    stretch    = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_due && !hold_taken) begin
        hold_taken = 1'b1;
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        rsp.ready <= 1'b1;
      end else begin
        rsp.ready <= 1'b1;
      end
      if (stretch == 0) begin
        stretch = $urandom_range(20, 200);
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 8;
          default: stall_pct = 25;
        endcase
      end else begin
        stretch--;
      end
    end
  end

  initial begin
    trace_req_t r;
    int         pick;
    // Hold every input at a known value from time zero.
    rst                   <= 1'b1;
    req.valid             <= 1'b0;
    req.opcode            <= OP_PUSH_TRACE;
    req.should_write_back <= 1'b0;
    req.has_write_back    <= 1'b0;
    req.tag               <= '0;
    req.instr_address     <= '0;
    req.instr_word        <= '0;
    req.privilege         <= '0;
    req.is_exception      <= 1'b0;
    req.is_interrupt      <= 1'b0;
    req.trap_cause        <= '0;
    req.trap_value        <= '0;
    req.data_word         <= '0;
    sent     = 0;
    gap_pct  = 0;
    calm     = 1'b0;
    hold_due = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty pop, ignored opcode, every record shape at the
    // extremes, a waiting head with nothing pending, a non-matching entry
    // ahead of the match, and duplicate tags taken oldest first.
    send(random_req(OP_POP));
    r        = '1;
    r.opcode = OP_UNUSED;
    send(r);
    r        = '1;
    r.opcode = OP_PUSH_TRACE;
    send(r);
    r        = '0;
    r.opcode = OP_PUSH_TRACE;
    send(r);
    r          = random_req(OP_PUSH_TRACE);
    r.needs_wb = 1'b0;
    r.has_wb   = 1'b1;
    send(r);
    send(waiting_rec(8'h5a));
    repeat (4) send(random_req(OP_POP));
    send(wb_for(8'h33));
    send(wb_for(8'h5a));
    send(wb_for(8'h5a));
    send(random_req(OP_POP));
    send(waiting_rec(8'h5a));
    send(waiting_rec(8'h33));
    repeat (3) send(random_req(OP_POP));

    // Random part: mostly well-formed batches, with floods and broken orders.
    while (sent < ITEM_TARGET) begin
      if (sent >= HOLD_AT) hold_due = 1'b1;
      calm = (sent >= ITEM_TARGET - CALM_TAIL);
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 10;
        default: gap_pct = 30;
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 80) run_batch();
      else if (pick < 86) run_queue_flood();
      else if (pick < 92) run_pending_flood();
      else run_stray();
    end

    // Drop valid and let every outstanding response arrive.
    req.valid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && owed == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
